// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tpcf_pkg.sv
// Shared constants and control/status types of the threshold pulse centroid finder.
package tpcf_pkg;

   localparam int unsigned INDEX_BITS_DEFAULT = 16;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned LOC_W    = 16;
   localparam int unsigned WIDTH_W  = 16;
   localparam int unsigned ORD_W    = 8;
   localparam int unsigned SEP_W    = 17;
   localparam int unsigned SUM_W    = 48;
   localparam int unsigned CNT_W    = 32;

   localparam int unsigned REQ_TDATA_W = SAMPLE_W;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_FIELDS_W = LOC_W + WIDTH_W + ORD_W + SEP_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int unsigned RSP_TUSER_W = 1;

   // Bit positions inside the request sideband.
   localparam int unsigned TUSER_FRAG = 0;
   localparam int unsigned TUSER_EVT  = 1;

   // One quotient bit per divider step.
   localparam int unsigned DIV_STEPS = SUM_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd20000;
   localparam logic [ORD_W-1:0]    ORD_FIRST       = 8'd0;
   localparam logic [ORD_W-1:0]    ORD_SECOND      = 8'd1;

   typedef struct packed {
      logic take_item;
      logic div_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic closes_pulse;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: hw/rtl/tpcf_ctrl.sv
// Controller state machine: sample intake, divider sequencing and result hand-off.
module tpcf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tpcf_pkg::dp_status_type status,
   output tpcf_pkg::ctrl_cmd_type  cmd
);
   import tpcf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_item = req_tvalid;
            if (req_tvalid && status.closes_pulse) begin
               state_in = ST_DIVIDE;
               step_in  = '0;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: hw/rtl/tpcf_datapath.sv
// Datapath: threshold register, accumulators, serial divider and output register.
module tpcf_datapath #(
   parameter int unsigned INDEX_BITS = tpcf_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tpcf_pkg::ctrl_cmd_type               cmd,
   output tpcf_pkg::dp_status_type              status,
   input  logic [tpcf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [tpcf_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                 csr_wr_en,
   input  logic [tpcf_pkg::SAMPLE_W-1:0]        csr_wr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tpcf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [tpcf_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);
   import tpcf_pkg::*;

   logic signed [SAMPLE_W-1:0] threshold_ff, threshold_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [INDEX_BITS-1:0]      pos_ff, pos_in;
   logic [ORD_W-1:0]           pulses_ff, pulses_in;
   logic [LOC_W-1:0]           first_ff, first_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]           divisor_ff, divisor_in;
   logic [ORD_W-1:0]           ord_ff, ord_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]     rsp_user_ff, rsp_user_in;

   logic signed [SAMPLE_W-1:0] sample;
   logic                       frag, evt, above;
   logic [SUM_W-1:0]           sum_eff;
   logic [CNT_W-1:0]           count_eff;
   logic [ORD_W-1:0]           pulses_eff;
   logic [LOC_W-1:0]           first_eff;
   logic [INDEX_BITS-1:0]      pos_eff;
   logic [SUM_W:0]             sum_add;
   logic [CNT_W:0]             trial, diff;
   logic [LOC_W-1:0]           loc;
   logic [WIDTH_W-1:0]         width_sat;
   logic                       sep_valid;
   logic [SEP_W-1:0]           sep;

   assign sample = signed'(req_tdata[SAMPLE_W-1:0]);
   assign frag   = req_tuser[TUSER_FRAG];
   assign evt    = req_tuser[TUSER_EVT];
   assign above  = sample > threshold_ff;

   // An event start clears the accumulators before this sample is used.
   assign sum_eff    = evt ? '0 : sum_ff;
   assign count_eff  = evt ? '0 : count_ff;
   assign pulses_eff = evt ? '0 : pulses_ff;
   assign first_eff  = evt ? '0 : first_ff;
   assign pos_eff    = (evt || frag) ? '0 : pos_ff;

   assign sum_add = {1'b0, sum_eff} + {{(SUM_W + 1 - INDEX_BITS){1'b0}}, pos_eff};

   assign status.closes_pulse = !above && (count_eff != '0);
   assign status.rsp_free     = !rsp_valid_ff || rsp_tready;

   // Restoring division step: one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   assign loc       = quo_ff[LOC_W-1:0];
   assign width_sat = (divisor_ff[CNT_W-1:WIDTH_W] != '0) ? '1 : divisor_ff[WIDTH_W-1:0];
   assign sep_valid = (ord_ff == ORD_SECOND);
   assign sep       = sep_valid ? ({1'b0, loc} - {1'b0, first_ff}) : '0;

   always_comb begin
      threshold_in = threshold_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      pulses_in    = pulses_ff;
      first_in     = first_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      ord_in       = ord_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_wr_en) begin
         threshold_in = signed'(csr_wr_data);
      end

      if (cmd.take_item) begin
         sum_in    = sum_eff;
         count_in  = count_eff;
         pulses_in = pulses_eff;
         first_in  = first_eff;
         pos_in    = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
         if (above) begin
            sum_in   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            count_in = (count_eff == '1) ? count_eff : count_eff + 1'b1;
         end else if (count_eff != '0) begin
            quo_in     = sum_eff;
            rem_in     = '0;
            divisor_in = count_eff;
            ord_in     = pulses_eff;
            pulses_in  = (pulses_eff == '1) ? pulses_eff : pulses_eff + 1'b1;
            sum_in     = '0;
            count_in   = '0;
         end
      end

      if (cmd.div_step) begin
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end

      if (cmd.load_rsp) begin
         if (ord_ff == ORD_FIRST) begin
            first_in = loc;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, sep, ord_ff, width_sat, loc};
         rsp_user_in  = sep_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= signed'(THRESHOLD_RESET);
         sum_ff       <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         pulses_ff    <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         pulses_ff    <= pulses_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      ord_ff      <= ord_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hw/rtl/threshold_pulse_centroid_finder_unit.sv
// Top level of the threshold pulse centroid finder: controller plus datapath.
//
// The req channel carries one ADC sample per word: tdata is the signed sample,
// tuser marks the first sample of a fragment (bit 0) and of an event (bit 1).
// A sample strictly above the threshold adds its index within the fragment to
// a running sum and bumps a count. The first sample at or below the threshold
// after such a run closes the pulse, and one word leaves on the rsp channel
// with the mean index, the run length, the pulse ordinal and, for the second
// pulse of an event, the separation from the first pulse.
// While the block is idle, samples that close no pulse stream at one word per
// cycle. A closing sample starts a restoring divider that produces one
// quotient bit per cycle; the result is then loaded into the output register
// once that register is free, and only then is the next sample accepted.
// The threshold is to be written through csr_wr_en/csr_wr_data only while the
// block is idle; the block itself does not enforce this. Reset sets the
// threshold to 20000, clears the running sum and count, the sample index, the
// pulse count and the first pulse location, and empties the output register.
// When the receiver stalls, the result word holds in the output register and
// the block keeps taking samples until a second result would need the register.
module threshold_pulse_centroid_finder_unit #(
   parameter int unsigned INDEX_BITS = tpcf_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input words.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_value[15:0]
   input  logic [tpcf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // fragment_start[0], event_start[1]
   input  logic [tpcf_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // Result words.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pulse_location[15:0], pulse_width[31:16], pulse_ordinal[39:32],
   // pulse_separation[56:40], zero padding[63:57]
   output logic [tpcf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // separation_valid[0]
   output logic [tpcf_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   // Threshold register write port.
   input  logic                               csr_wr_en,
   input  logic [tpcf_pkg::SAMPLE_W-1:0]      csr_wr_data
);
   import tpcf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences intake, division and the result hand-off.
   tpcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns every accumulator, the divider and the output register.
   tpcf_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// File: hw/rtl/tpcf_checker.sv
// Port-level checker of the threshold pulse centroid finder and its bind.
`include "assert_macros.svh"

module tpcf_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tpcf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic [tpcf_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import tpcf_pkg::*;

   // A stalled result word holds until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // The separation flag is set for the second pulse of an event and only then.
   `ASSERT_SAME(a_sep_flag, clock, reset, rsp_tvalid, rsp_tuser[0] == (rsp_tdata[39:32] == ORD_SECOND), "separation flag disagrees with ordinal")

   // Every reported pulse has at least one sample above the threshold.
   `ASSERT_SAME(a_width_nonzero, clock, reset, rsp_tvalid, rsp_tdata[31:16] != '0, "pulse reported with zero width")

   // Without a valid separation the field and the padding read as zero.
   `ASSERT_SAME(a_sep_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[63:40] == '0, "separation not zero for a pulse other than the second")

endmodule

bind threshold_pulse_centroid_finder_unit tpcf_checker u_tpcf_checker (.*);

// File: test/threshold_pulse_centroid_finder_unit_tb.sv
// Self-checking testbench of the threshold pulse centroid finder unit.
module threshold_pulse_centroid_finder_unit_tb;
   import tpcf_pkg::*;

   // The unit is built with its default index width, and the local
   // tracker follows the same width.
   localparam int unsigned INDEX_BITS = INDEX_BITS_DEFAULT;

   // A closing sample keeps the unit busy through the division and the result
   // hand-off, so the settle pause before a threshold write and at the end covers that with margin.
   localparam int SETTLE_CYCLES   = 60;
   // The longest quiet stretch of a correct run is the receiver hold-off
   // below plus one division. The watchdog allows several times that.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASE_WORDS     = 60;

   // Bit offsets of the fields inside the result word.
   localparam int WIDTH_LSB = LOC_W;
   localparam int ORD_LSB   = WIDTH_LSB + WIDTH_W;
   localparam int SEP_LSB   = ORD_LSB + ORD_W;

   // One expected pulse report, with the fields of one result word.
   typedef struct packed {
      logic [LOC_W-1:0]   location;
      logic [WIDTH_W-1:0] width;
      logic [ORD_W-1:0]   ordinal;
      logic               sep_valid;
      logic [SEP_W-1:0]   separation;
   } pulse_report_type;

   // Clock, reset and the ports of the unit. Every input starts at a known
   // value and reset is high from time zero.
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [REQ_TUSER_W-1:0] req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [SAMPLE_W-1:0]    csr_wr_data = '0;

   // Local copy of the unit's state and threshold, as it stands after reset.
   logic signed [SAMPLE_W-1:0] level_threshold = THRESHOLD_RESET;
   logic [SUM_W-1:0]           run_index_total = '0;
   logic [CNT_W-1:0]           run_length      = '0;
   logic [INDEX_BITS-1:0]      next_index      = '0;
   logic [ORD_W-1:0]           pulse_tally     = '0;
   logic [LOC_W-1:0]           lead_location   = '0;

   // Reports that the unit still owes, oldest first.
   pulse_report_type pending_pulses[$];

   int mismatches    = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 60;
   int hold_request  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   threshold_pulse_centroid_finder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Advances the local state by one accepted sample word and queues the
   // report that the sample closes, if it closes a pulse.
   function automatic void track_sample(input logic signed [SAMPLE_W-1:0] level,
                                         input logic frag, input logic evt);
      logic [SUM_W:0]   total;
      logic [SUM_W-1:0] mean;
      pulse_report_type report;
      // An event start clears the open pulse and the pulse count, and
      // either start flag puts the sample at index zero.
      if (evt) begin
         run_index_total = '0;
         run_length      = '0;
         pulse_tally     = '0;
         lead_location   = '0;
      end
      if (evt || frag) begin
         next_index = '0;
      end
      if (level > level_threshold) begin
         total           = {1'b0, run_index_total} + (SUM_W + 1)'(next_index);
         run_index_total = total[SUM_W] ? '1 : total[SUM_W-1:0];
         if (run_length != '1) begin
            run_length = run_length + 1'b1;
         end
      end else if (run_length != '0) begin
         // The test is on the count, so a pulse made only of index zero
         // still closes and reports location zero.
         mean              = run_index_total / SUM_W'(run_length);
         report.location   = mean[LOC_W-1:0];
         report.width      = (run_length > CNT_W'({WIDTH_W{1'b1}})) ?
                             '1 : run_length[WIDTH_W-1:0];
         report.ordinal    = pulse_tally;
         report.sep_valid  = 1'b0;
         report.separation = '0;
         if (pulse_tally == ORD_FIRST) begin
            lead_location = report.location;
         end else if (pulse_tally == ORD_SECOND) begin
            report.sep_valid  = 1'b1;
            report.separation = {1'b0, report.location} - {1'b0, lead_location};
         end
         if (pulse_tally != '1) begin
            pulse_tally = pulse_tally + 1'b1;
         end
         pending_pulses.insert(pending_pulses.size(), report);
         run_index_total = '0;
         run_length      = '0;
      end
      // The index stops at its top value in a long fragment.
      if (next_index != '1) begin
         next_index = next_index + 1'b1;
      end
   endfunction

   // A random level strictly above the current threshold, often the closest
   // one. At the top threshold no such level exists and the top is returned.
   function automatic logic signed [SAMPLE_W-1:0] above_level();
      int lo;
      lo = int'(level_threshold) + 1;
      if (lo > 32767) begin
         lo = 32767;
      end
      if ($urandom_range(3) == 0) begin
         return SAMPLE_W'(lo);
      end
      return SAMPLE_W'(lo + int'($urandom_range(32767 - lo)));
   endfunction

   // A random level at or below the current threshold, often equal to it.
   function automatic logic signed [SAMPLE_W-1:0] below_level();
      int hi;
      hi = int'(level_threshold);
      if ($urandom_range(3) == 0) begin
         return SAMPLE_W'(hi);
      end
      return SAMPLE_W'(-32768 + int'($urandom_range(hi + 32768)));
   endfunction

   // Offers one sample word after a random number of idle cycles and waits
   // for the handshake. The valid stays high after acceptance, so that back
   // to back words need no extra assignment within one time step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] level,
                              input logic frag, input logic evt);
      logic [REQ_TUSER_W-1:0] flags;
      flags             = '0;
      flags[TUSER_FRAG] = frag;
      flags[TUSER_EVT]  = evt;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= level;
      req_tuser  <= flags;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      track_sample(level, frag, evt);
   endtask

   // Stops offering words, waits for every owed report and then lets the
   // unit settle, so that it is idle afterwards.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pulses.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the threshold register while the unit is idle.
   task automatic write_threshold(input logic signed [SAMPLE_W-1:0] level);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      level_threshold = level;
   endtask

   // The threshold after reset: a level equal to it is not part of a pulse,
   // one above it is, and the mean of indexes one and two truncates to one.
   task automatic test_reset_threshold();
      send_sample(20000, 1'b1, 1'b1);
      send_sample(20001, 1'b0, 1'b0);
      send_sample(32767, 1'b0, 1'b0);
      send_sample(20000, 1'b0, 1'b0);
   endtask

   // A pulse made only of index zero, at the extremes of the sample range,
   // followed by a second pulse that reports a positive separation.
   task automatic test_index_zero_pulse();
      send_sample(32767, 1'b1, 1'b1);
      send_sample(SAMPLE_W'(-32768), 1'b0, 1'b0);
      send_sample(25000, 1'b0, 1'b0);
      send_sample(0, 1'b0, 1'b0);
   endtask

   // A new fragment without a new event puts the second pulse before the
   // first, so the separation is negative. The third pulse has none.
   task automatic test_negative_separation();
      send_sample(0, 1'b1, 1'b1);
      repeat (3) send_sample(25000, 1'b0, 1'b0);
      send_sample(0, 1'b0, 1'b0);
      send_sample(25000, 1'b1, 1'b0);
      send_sample(0, 1'b0, 1'b0);
      send_sample(25000, 1'b0, 1'b0);
      send_sample(0, 1'b0, 1'b0);
   endtask

   // A fragment boundary does not clear the sums, so a pulse can span it.
   task automatic test_fragment_spanning();
      send_sample(0, 1'b1, 1'b1);
      send_sample(30000, 1'b0, 1'b0);
      send_sample(30000, 1'b0, 1'b0);
      send_sample(30000, 1'b1, 1'b0);
      send_sample(0, 1'b0, 1'b0);
   endtask

   // A pulse still open when the next event starts is dropped. That event
   // start comes without a fragment start and still restarts the index.
   task automatic test_open_pulse_dropped();
      send_sample(30000, 1'b1, 1'b1);
      send_sample(30000, 1'b0, 1'b0);
      send_sample(0, 1'b0, 1'b1);
      send_sample(30000, 1'b0, 1'b0);
      send_sample(0, 1'b0, 1'b0);
   endtask

   // More than 256 pulses in one event, so the ordinal stops at its top.
   task automatic test_ordinal_saturation();
      send_sample(below_level(), 1'b1, 1'b1);
      for (int p = 0; p < 260; p++) begin
         send_sample(above_level(), 1'b0, 1'b0);
         send_sample(below_level(), 1'b0, 1'b0);
      end
   endtask

   // The receiver holds off for a long stretch while short pulses keep
   // coming, so the output register fills and the unit stalls its input.
   // Then the sender pauses until every report has come.
   task automatic test_output_stall();
      send_sample(below_level(), 1'b1, 1'b1);
      hold_request = HOLD_OFF_CYCLES;
      for (int p = 0; p < 20; p++) begin
         send_sample(above_level(), 1'b0, 1'b0);
         send_sample(below_level(), 1'b0, 1'b0);
      end
      wait_idle();
   endtask

   // Random traffic in phases, each under its own threshold, the extremes
   // among them. Most words form runs above and below the threshold with
   // random lengths and levels. A few are raw random levels, and start flags
   // are sprinkled in, which also cut pulses short at event starts.
   task automatic test_random_traffic();
      logic signed [SAMPLE_W-1:0] level;
      logic                       frag;
      logic                       evt;
      logic                       high_run;
      int                         run_left;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       level = SAMPLE_W'(-32768);
            1:       level = SAMPLE_W'(32767);
            3:       level = SAMPLE_W'(0);
            5:       level = THRESHOLD_RESET;
            default: level = SAMPLE_W'($urandom);
         endcase
         write_threshold(level);
         // First the sender idles less than the receiver, then the other way
         // round, then neither side idles.
         send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 60 : 0;
         recv_idle_pct = (phase < 2) ? 60 : (phase < 4) ? 26 : 0;
         high_run = 1'b0;
         run_left = 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (run_left == 0) begin
               high_run = ~high_run;
               run_left = ($urandom_range(9) == 0) ? $urandom_range(40, 1) :
                          $urandom_range(4, 1);
            end
            run_left--;
            evt  = ($urandom_range(99) < 2);
            frag = evt ? ($urandom_range(3) != 0) : ($urandom_range(99) < 3);
            if ($urandom_range(9) == 0) begin
               level = SAMPLE_W'($urandom);
            end else begin
               level = high_run ? above_level() : below_level();
            end
            send_sample(level, frag, evt);
         end
      end
   endtask

   // Receiver: random ready, or a hold-off counted down here when a test
   // asks for one.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Each accepted result word is compared with the oldest owed report.
   always @(posedge clock) begin : check_pulses
      pulse_report_type got;
      pulse_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.location   = rsp_tdata[LOC_W-1:0];
         got.width      = rsp_tdata[WIDTH_LSB +: WIDTH_W];
         got.ordinal    = rsp_tdata[ORD_LSB +: ORD_W];
         got.sep_valid  = rsp_tuser[0];
         got.separation = rsp_tdata[SEP_LSB +: SEP_W];
         if (pending_pulses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected pulse word: loc %0d width %0d ord %0d sv %0b sep %h",
                        got.location, got.width, got.ordinal, got.sep_valid,
                        got.separation);
            end
         end else begin
            want = pending_pulses.pop_front();
            if (got.location !== want.location || got.width !== want.width ||
                got.ordinal !== want.ordinal || got.sep_valid !== want.sep_valid ||
                got.separation !== want.separation) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("pulse mismatch: expected loc %0d width %0d ord %0d sv %0b sep %h",
                           want.location, want.width, want.ordinal, want.sep_valid,
                           want.separation);
                  $display("                got      loc %0d width %0d ord %0d sv %0b sep %h",
                           got.location, got.width, got.ordinal, got.sep_valid,
                           got.separation);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_threshold();
      test_index_zero_pulse();
      test_negative_separation();
      test_fragment_spanning();
      test_open_pulse_dropped();
      test_ordinal_saturation();
      test_output_stall();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0 && pending_pulses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tpcf_pkg.sv
hw/rtl/tpcf_ctrl.sv
hw/rtl/tpcf_datapath.sv
hw/rtl/threshold_pulse_centroid_finder_unit.sv
hw/rtl/tpcf_checker.sv
test/threshold_pulse_centroid_finder_unit_tb.sv
